// File: rtl/core/htlm_pkg.sv
// Package for the hierarchical tree lock manager.
// Holds widths, node word type, operation and state codes, divider link types.
// No dependencies.
package htlm_pkg;

	localparam int NODES  = 1024;
	localparam int ADDR_W = $clog2(NODES);
	localparam int UID_W  = 16;
	localparam int CNT_W  = 10;
	localparam int M_W    = 10;
	localparam int N_W    = 11;
	localparam int LVL_W  = 2 * ADDR_W + 1;

	typedef enum logic [1:0] {
		OP_LOCK    = 2'd0,
		OP_UNLOCK  = 2'd1,
		OP_UPGRADE = 2'd2
	} op_t;

	typedef enum logic {
		CFG_BRANCH = 1'b0,
		CFG_NODES  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic             valid;
		logic [UID_W-1:0] owner;
		logic [CNT_W-1:0] cnt;
	} node_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] dividend;
		logic [M_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [ADDR_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_P_RD,
		ST_P_CK,
		ST_P_DIV,
		ST_P_END,
		ST_W_STEP,
		ST_W_DIV,
		ST_W_RD,
		ST_W_WR,
		ST_U_RD,
		ST_U_CK,
		ST_S_LVL,
		ST_S_RD,
		ST_S_CK,
		ST_S_NEXT,
		ST_S_MUL1,
		ST_S_MUL2,
		ST_DONE
	} state_t;

endpackage

// File: rtl/core/htlm_if.sv
// Request and response channel interfaces for the tree lock manager.
// Depends on htlm_pkg.
interface htlm_req_if import htlm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [ADDR_W-1:0]   node_index;
	logic [UID_W-1:0]    user_id;

	modport source (output valid, func, node_index, user_id, input ready);
	modport sink (input valid, func, node_index, user_id, output ready);
endinterface

interface htlm_rsp_if;
	logic valid;
	logic ready;
	logic granted;
	logic bad_index;

	modport source (output valid, granted, bad_index, input ready);
	modport sink (input valid, granted, bad_index, output ready);
endinterface

// File: rtl/core/htlm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on htlm_pkg.
module htlm_div import htlm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam logic [$clog2(ADDR_W)-1:0] LAST = ($clog2(ADDR_W))'(ADDR_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [$clog2(ADDR_W)-1:0]  cnt_q;
	logic [ADDR_W-1:0]          quo_q;
	logic [M_W-1:0]             rem_q;
	logic [M_W-1:0]             dsr_q;
	logic [M_W:0]               rem_sh;
	logic                       ge;
	logic [M_W:0]               rem_n;

	assign rem_sh = {rem_q, quo_q[ADDR_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_n  = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ADDR_W-2:0], ge};
			rem_q <= rem_n[M_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
endmodule

// File: rtl/core/htlm_mem.sv
// Node store: lock flag, owner and locked-descendant count per node.
// One write port, one registered read port. Depends on htlm_pkg.
module htlm_mem import htlm_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  node_t             wdata,
	input  logic [ADDR_W-1:0] raddr,
	output node_t             rdata
);
	node_t mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/hierarchical_tree_lock_manager.sv
// Hierarchical lock manager over a complete m-ary tree, one request at a time.
// Lock first checks the ancestors, stepping up one level at a time through the shared
// divider, then walks them again for the count update; unlock does only the update.
// Upgrade adds a level-by-level scan of the subtree on each of two passes,
// plus an update walk per released node. A new request is taken only when idle.
// After reset all 1024 entries of the node store are swept clear before ready.
module hierarchical_tree_lock_manager import htlm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [N_W-1:0] cfg_wdata,
	htlm_req_if.sink   req,
	htlm_rsp_if.source rsp
);
	state_t state_q, state_d;

	logic [M_W-1:0]    m_q;
	logic [N_W-1:0]    n_q;
	logic [M_W-1:0]    m_eff;
	logic [N_W-1:0]    n_eff;

	logic [ADDR_W-1:0] idx_q, cur_q, j_q, clr_q;
	logic [UID_W-1:0]  uid_q;
	logic [CNT_W-1:0]  cnti_q;
	logic [LVL_W-1:0]  lo_q, hi_q;
	logic              upg_q, pass_q, up_q, ret_scan_q;
	logic              res_g, res_b, res_g_q, res_b_q;
	logic              rsp_valid_q, rsp_granted_q, rsp_bad_q;

	logic              we;
	logic [ADDR_W-1:0] waddr, raddr;
	node_t             wdata, rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic [ADDR_W-1:0]   mul_a;
	logic [2*ADDR_W-1:0] prod;
	logic                acc;

	assign m_eff = (m_q == '0) ? M_W'(1) : m_q;
	assign n_eff = (n_q > N_W'(NODES)) ? N_W'(NODES) : n_q;
	assign mul_a = (state_q == ST_S_MUL1) ? lo_q[ADDR_W-1:0] : hi_q[ADDR_W-1:0];
	assign prod  = mul_a * m_eff;
	assign acc   = req.valid && req.ready;

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.granted   = rsp_granted_q;
	assign rsp.bad_index = rsp_bad_q;

	htlm_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	htlm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= M_W'(2);
			n_q <= N_W'(NODES);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BRANCH: m_q <= cfg_wdata[M_W-1:0];
				CFG_NODES:  n_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d          = state_q;
		we               = 1'b0;
		waddr            = cur_q;
		wdata            = rdata;
		raddr            = cur_q;
		div_req.start    = 1'b0;
		div_req.dividend = cur_q - 1'b1;
		div_req.divisor  = m_eff;
		res_g            = 1'b0;
		res_b            = 1'b0;
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					if ({1'b0, req.node_index} >= n_eff) begin
						res_b   = 1'b1;
						state_d = ST_DONE;
					end else begin
						case (op_t'(req.func))
							OP_LOCK, OP_UPGRADE: state_d = ST_P_RD;
							OP_UNLOCK:           state_d = ST_U_RD;
							default:             state_d = ST_DONE;
						endcase
					end
				end
			end
			ST_P_RD: state_d = ST_P_CK;
			ST_P_CK: begin
				if (rdata.valid) state_d = ST_DONE;
				else if (cur_q == '0) state_d = ST_P_END;
				else begin
					div_req.start = 1'b1;
					state_d       = ST_P_DIV;
				end
			end
			ST_P_DIV: if (div_rsp.done) state_d = ST_P_RD;
			ST_P_END: begin
				if (!upg_q) begin
					if (cnti_q != '0) state_d = ST_DONE;
					else begin
						we          = 1'b1;
						waddr       = idx_q;
						wdata.valid = 1'b1;
						wdata.owner = uid_q;
						wdata.cnt   = cnti_q;
						state_d     = ST_W_STEP;
					end
				end else begin
					if (cnti_q == '0) state_d = ST_DONE;
					else state_d = ST_S_LVL;
				end
			end
			ST_W_STEP: begin
				if (cur_q == '0) begin
					if (ret_scan_q) state_d = ST_S_NEXT;
					else begin
						res_g   = 1'b1;
						state_d = ST_DONE;
					end
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_W_DIV;
				end
			end
			ST_W_DIV: if (div_rsp.done) state_d = ST_W_RD;
			ST_W_RD:  state_d = ST_W_WR;
			ST_W_WR: begin
				we        = 1'b1;
				wdata.cnt = up_q ? rdata.cnt + 1'b1 : rdata.cnt - 1'b1;
				state_d   = ST_W_STEP;
			end
			ST_U_RD: begin
				raddr   = idx_q;
				state_d = ST_U_CK;
			end
			ST_U_CK: begin
				if (!rdata.valid || rdata.owner != uid_q) state_d = ST_DONE;
				else begin
					we          = 1'b1;
					waddr       = idx_q;
					wdata.valid = 1'b0;
					state_d     = ST_W_STEP;
				end
			end
			ST_S_LVL: begin
				if (lo_q >= LVL_W'(n_eff)) state_d = pass_q ? ST_P_RD : ST_S_LVL;
				else state_d = ST_S_RD;
			end
			ST_S_RD: begin
				raddr   = j_q;
				state_d = ST_S_CK;
			end
			ST_S_CK: begin
				state_d = ST_S_NEXT;
				if (rdata.valid) begin
					if (!pass_q) begin
						if (rdata.owner != uid_q) state_d = ST_DONE;
					end else if (rdata.owner == uid_q) begin
						we          = 1'b1;
						waddr       = j_q;
						wdata.valid = 1'b0;
						state_d     = ST_W_STEP;
					end
				end
			end
			ST_S_NEXT: state_d = (LVL_W'(j_q) == hi_q) ? ST_S_MUL1 : ST_S_RD;
			ST_S_MUL1: state_d = ST_S_MUL2;
			ST_S_MUL2: state_d = ST_S_LVL;
			ST_DONE:   if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_d == ST_DONE && state_q != ST_DONE) begin
			res_g_q <= res_g;
			res_b_q <= res_b;
		end
		if (state_q == ST_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_granted_q <= res_g_q;
			rsp_bad_q     <= res_b_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					idx_q <= req.node_index;
					cur_q <= req.node_index;
					uid_q <= req.user_id;
					upg_q <= (op_t'(req.func) == OP_UPGRADE);
				end
			end
			ST_P_CK: if (cur_q == idx_q) cnti_q <= rdata.cnt;
			ST_P_DIV, ST_W_DIV: if (div_rsp.done) cur_q <= div_rsp.quot;
			ST_P_END: begin
				cur_q      <= idx_q;
				up_q       <= 1'b1;
				ret_scan_q <= 1'b0;
				lo_q       <= LVL_W'(idx_q);
				hi_q       <= LVL_W'(idx_q);
				pass_q     <= 1'b0;
			end
			ST_U_CK: begin
				cur_q      <= idx_q;
				up_q       <= 1'b0;
				ret_scan_q <= 1'b0;
			end
			ST_S_LVL: begin
				if (lo_q >= LVL_W'(n_eff)) begin
					pass_q <= 1'b1;
					lo_q   <= LVL_W'(idx_q);
					hi_q   <= LVL_W'(idx_q);
					cur_q  <= idx_q;
					upg_q  <= 1'b0;
				end else begin
					j_q <= lo_q[ADDR_W-1:0];
					if (hi_q > LVL_W'(n_eff - 1'b1)) hi_q <= LVL_W'(n_eff - 1'b1);
				end
			end
			ST_S_CK: begin
				cur_q      <= j_q;
				up_q       <= 1'b0;
				ret_scan_q <= 1'b1;
			end
			ST_S_NEXT: j_q <= j_q + 1'b1;
			ST_S_MUL1: lo_q <= LVL_W'(prod) + 1'b1;
			ST_S_MUL2: hi_q <= LVL_W'(prod) + LVL_W'(m_eff);
			default: ;
		endcase
	end

	a_rsp_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.granted && rsp.bad_index))
		else $error("granted response flagged as bad index");

	a_div_use: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_P_DIV || state_q == ST_W_DIV))
		else $error("divider finished outside a parent step");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !we)
		else $error("node store written while no request in flight");
endmodule
